// ===== hw/rtl/ncda_pkg.sv =====
// Shared types and constants for the nines' complement decimal adder core.
// Used by the digit cell, the cell row, the result stage and the top level.
// Depends on nothing.
package ncda_pkg;

   localparam int unsigned MAX_DIGITS = 16;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned DATA_W     = MAX_DIGITS * DIGIT_W;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned DEC_BASE   = 10;
   localparam int unsigned DEC_NINE   = 9;

   // Request tdata layout, lowest bit first.
   localparam int unsigned REQ_A_LSB      = 0;
   localparam int unsigned REQ_A_SIGN     = REQ_A_LSB + DATA_W;
   localparam int unsigned REQ_B_LSB      = REQ_A_SIGN + 1;
   localparam int unsigned REQ_B_SIGN     = REQ_B_LSB + DATA_W;
   localparam int unsigned REQ_USED_W     = REQ_B_SIGN + 1;
   localparam int unsigned REQ_TDATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } ncda_op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_POS_OVF = 2'd1,
      STATUS_NEG_OVF = 2'd2
   } ncda_status_type;

   // Word that travels along a row of digit cells. Each cell adds digit
   // pair x/y at its own position plus the incoming carry into r.
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] r;
      logic              carry;
      logic              x_sign;
      logic              y_sign;
      ncda_status_type   status;
   } ncda_word_type;

   // Result transaction, packed so that sum_digits lands in the lowest bits.
   typedef struct packed {
      ncda_status_type   status;
      logic [LEN_W-1:0]  sig_length;
      logic              sum_sign;
      logic [DATA_W-1:0] sum_digits;
   } ncda_result_type;

   localparam int unsigned RSP_TDATA_W = $bits(ncda_result_type);

endpackage

// ===== hw/rtl/ncda_digit_cell.sv =====
// One decimal digit cell: adds the digit pair at position INDEX with the
// carry from the cell for the next lower digit and registers the word for the next cell.
// Depends on ncda_pkg.
module ncda_digit_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  ncda_pkg::ncda_word_type up_word,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output ncda_pkg::ncda_word_type dn_word
);

   localparam int unsigned DW = ncda_pkg::DIGIT_W;
   localparam logic [DW:0] TEN    = (DW+1)'(ncda_pkg::DEC_BASE);
   localparam logic [DW:0] TWENTY = (DW+1)'(2 * ncda_pkg::DEC_BASE);
   localparam logic [DW:0] THIRTY = (DW+1)'(3 * ncda_pkg::DEC_BASE);

   logic                    valid_ff;
   logic                    valid_in;
   ncda_pkg::ncda_word_type word_ff;
   ncda_pkg::ncda_word_type word_in;
   logic [DW:0]             digit_sum;
   logic [DW-1:0]           digit;

   always_comb begin
      digit_sum = {1'b0, up_word.x[DW*INDEX +: DW]} + {1'b0, up_word.y[DW*INDEX +: DW]}
                  + {{DW{1'b0}}, up_word.carry};
      // Digits above nine can push the sum past 19, so reduce by up to three tens.
      if (digit_sum >= THIRTY) begin
         digit = DW'(digit_sum - THIRTY);
      end else if (digit_sum >= TWENTY) begin
         digit = DW'(digit_sum - TWENTY);
      end else if (digit_sum >= TEN) begin
         digit = DW'(digit_sum - TEN);
      end else begin
         digit = DW'(digit_sum);
      end
      word_in                    = up_word;
      word_in.r[DW*INDEX +: DW]  = digit;
      word_in.carry              = (digit_sum >= TEN);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

// ===== hw/rtl/ncda_cell_row.sv =====
// Row of DIGITS digit cells that ripples a decimal carry one digit per stage.
// Depends on ncda_pkg and ncda_digit_cell.
module ncda_cell_row #(
   parameter int unsigned DIGITS = ncda_pkg::MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  ncda_pkg::ncda_word_type up_word,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output ncda_pkg::ncda_word_type dn_word
);

   logic                    chain_valid [DIGITS+1];
   logic                    chain_ready [DIGITS+1];
   ncda_pkg::ncda_word_type chain_word  [DIGITS+1];

   assign chain_valid[0]      = up_valid;
   assign chain_word[0]       = up_word;
   assign up_ready            = chain_ready[0];
   assign chain_ready[DIGITS] = dn_ready;
   assign dn_valid            = chain_valid[DIGITS];
   assign dn_word             = chain_word[DIGITS];

   genvar g;
   for (g = 0; g < DIGITS; g++) begin : g_cell
      ncda_digit_cell #(
         .INDEX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_valid(chain_valid[g]),
         .up_ready(chain_ready[g]),
         .up_word (chain_word[g]),
         .dn_valid(chain_valid[g+1]),
         .dn_ready(chain_ready[g+1]),
         .dn_word (chain_word[g+1])
      );
   end

endmodule

// ===== hw/rtl/ncda_result_stage.sv =====
// Output stage: applies the final end-around fix, the late overflow check and
// the significant length search, and holds the result transaction.
// Depends on ncda_pkg.
module ncda_result_stage #(
   parameter int unsigned DIGITS = ncda_pkg::MAX_DIGITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  ncda_pkg::ncda_word_type   up_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ncda_pkg::ncda_result_type rsp_result
);

   localparam int unsigned DW    = ncda_pkg::DIGIT_W;
   localparam int unsigned LEN_W = ncda_pkg::LEN_W;

   logic                      valid_ff;
   logic                      valid_in;
   ncda_pkg::ncda_result_type result_ff;
   ncda_pkg::ncda_result_type result_in;
   logic                      res_sign;
   logic [DW-1:0]             fill;
   logic [LEN_W-1:0]          length;

   always_comb begin
      res_sign             = up_word.x_sign ^ up_word.carry;
      result_in.sum_digits = up_word.r;
      // A carry out of the increment row means every digit wrapped to zero;
      // the second end-around carry then leaves a one in the lowest digit.
      if (up_word.carry) begin
         result_in.sum_digits[DW-1:0] = DW'(1);
      end
      result_in.sum_sign = res_sign;
      result_in.status   = up_word.status;
      if (up_word.status == ncda_pkg::STATUS_OK && !up_word.x_sign && res_sign) begin
         result_in.status = ncda_pkg::STATUS_POS_OVF;
      end
      fill   = res_sign ? DW'(ncda_pkg::DEC_NINE) : '0;
      length = LEN_W'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (result_in.sum_digits[DW*i +: DW] != fill) begin
            length = LEN_W'(i + 1);
         end
      end
      result_in.sig_length = length;
   end

   assign up_ready = !valid_ff || rsp_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== hw/rtl/nines_complement_decimal_adder_core.sv =====
// Top level of the nines' complement decimal adder/subtractor.
// Depends on ncda_pkg, ncda_cell_row and ncda_result_stage.
//
// Usage: each request transaction carries two signed decimal operands in
// nines' complement BCD with a sign bit each, and tuser selects add or
// subtract. Each request yields exactly one response transaction holding the
// wrapped sum, its sign, the count of significant digits and an overflow code.
// On its way from acceptance to rsp_tvalid a request passes a first row of
// DIGITS cells that ripples the decimal carry one digit per cell, a second row of
// DIGITS cells that ripples the end-around increment, and one output register that
// finishes the result. Throughput is one transaction per cycle while the receiver
// does not stall, since every cell is a register stage that passes its word on each such cycle.
// Reset empties every stage. When the receiver holds rsp_tready low the full
// stages hold their words while empty stages further up keep filling, so
// requests are still taken until the whole pipeline is occupied.
module nines_complement_decimal_adder_core #(
   parameter int unsigned DIGITS = ncda_pkg::MAX_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // a_digits, a_sign, b_digits, b_sign, zero fill
   input  logic [ncda_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sum_digits, sum_sign, sig_length, status
   output logic [ncda_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned DW     = ncda_pkg::DIGIT_W;
   localparam int unsigned DATA_W = ncda_pkg::DATA_W;

   ncda_pkg::ncda_word_type   entry_word;
   ncda_pkg::ncda_word_type   sum_word;
   ncda_pkg::ncda_word_type   incr_word;
   ncda_pkg::ncda_word_type   final_word;
   ncda_pkg::ncda_result_type result;
   logic [DATA_W-1:0]         b_raw;
   logic                      is_sub;
   logic                      sum_valid;
   logic                      sum_ready;
   logic                      final_valid;
   logic                      final_ready;
   logic                      first_sign;

   // Subtraction complements every digit of the second operand and flips its sign.
   always_comb begin
      is_sub              = (req_tuser == ncda_pkg::OP_SUB);
      b_raw               = req_tdata[ncda_pkg::REQ_B_LSB +: DATA_W];
      entry_word.x        = req_tdata[ncda_pkg::REQ_A_LSB +: DATA_W];
      entry_word.y        = b_raw;
      if (is_sub) begin
         for (int i = 0; i < DIGITS; i++) begin
            entry_word.y[DW*i +: DW] = DW'(ncda_pkg::DEC_NINE) - b_raw[DW*i +: DW];
         end
      end
      entry_word.r        = '0;
      entry_word.carry    = 1'b0;
      entry_word.x_sign   = req_tdata[ncda_pkg::REQ_A_SIGN];
      entry_word.y_sign   = req_tdata[ncda_pkg::REQ_B_SIGN] ^ is_sub;
      entry_word.status   = ncda_pkg::STATUS_OK;
   end

   ncda_cell_row #(
      .DIGITS(DIGITS)
   ) u_sum_row (
      .clock   (clock),
      .reset   (reset),
      .up_valid(req_tvalid),
      .up_ready(req_tready),
      .up_word (entry_word),
      .dn_valid(sum_valid),
      .dn_ready(sum_ready),
      .dn_word (sum_word)
   );

   // The sign acts as a modulo-2 top digit. The overflow check uses the
   // operand signs, and the carry out becomes the end-around increment.
   always_comb begin
      first_sign       = sum_word.x_sign ^ sum_word.y_sign ^ sum_word.carry;
      incr_word.x      = sum_word.r;
      incr_word.y      = '0;
      incr_word.r      = '0;
      incr_word.carry  = sum_word.carry;
      incr_word.x_sign = first_sign;
      incr_word.y_sign = 1'b0;
      incr_word.status = ncda_pkg::STATUS_OK;
      if (sum_word.x_sign == sum_word.y_sign) begin
         if (sum_word.x_sign && !first_sign) begin
            incr_word.status = ncda_pkg::STATUS_NEG_OVF;
         end else if (!sum_word.x_sign && first_sign) begin
            incr_word.status = ncda_pkg::STATUS_POS_OVF;
         end
      end
   end

   ncda_cell_row #(
      .DIGITS(DIGITS)
   ) u_incr_row (
      .clock   (clock),
      .reset   (reset),
      .up_valid(sum_valid),
      .up_ready(sum_ready),
      .up_word (incr_word),
      .dn_valid(final_valid),
      .dn_ready(final_ready),
      .dn_word (final_word)
   );

   ncda_result_stage #(
      .DIGITS(DIGITS)
   ) u_result (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (final_valid),
      .up_ready  (final_ready),
      .up_word   (final_word),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_result(result)
   );

   assign rsp_tdata = result;

endmodule

// ===== dv/ncda_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the nines' complement decimal adder core: it predicts each
// response from the accepted request and compares it field by field.
// Depends on ncda_pkg.
module ncda_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // a_digits, a_sign, b_digits, b_sign, zero fill
   input  logic [ncda_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sum_digits, sum_sign, sig_length, status
   input  logic [ncda_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int unsigned                      error_count,
   output int unsigned                      pending
);

   ncda_pkg::ncda_result_type expected_sums[$];
   ncda_pkg::ncda_result_type want;
   ncda_pkg::ncda_result_type got;
   int unsigned               errors = 0;
   int unsigned               waiting = 0;

   assign error_count = errors;
   assign pending     = waiting;

   // One ripple of decimal carry across every digit; the signs act as a
   // modulo-2 digit above the top one.
   function automatic logic [ncda_pkg::DATA_W-1:0] digit_row_add(
      input  logic [ncda_pkg::DATA_W-1:0] x,
      input  logic                        x_sign,
      input  logic [ncda_pkg::DATA_W-1:0] y,
      input  logic                        y_sign,
      output logic                        sign,
      output logic                        carry
   );
      logic [ncda_pkg::DATA_W-1:0] r;
      logic [4:0]                  s;
      logic                        c;
      int unsigned                 i;
      r = '0;
      c = 1'b0;
      for (i = 0; i < ncda_pkg::MAX_DIGITS; i++) begin
         s = 5'(x[4*i +: 4]) + 5'(y[4*i +: 4]) + 5'(c);
         r[4*i +: 4] = 4'(s % ncda_pkg::DEC_BASE);
         c = (s >= ncda_pkg::DEC_BASE);
      end
      sign  = x_sign ^ y_sign ^ c;
      carry = c;
      return r;
   endfunction

   function automatic ncda_pkg::ncda_result_type decimal_sum(
      input ncda_pkg::ncda_op_type       op,
      input logic [ncda_pkg::DATA_W-1:0] a,
      input logic                        a_sign,
      input logic [ncda_pkg::DATA_W-1:0] b,
      input logic                        b_sign
   );
      ncda_pkg::ncda_result_type   res;
      ncda_pkg::ncda_status_type   status;
      logic [ncda_pkg::DATA_W-1:0] r;
      logic [ncda_pkg::DATA_W-1:0] nr;
      logic                        rs;
      logic                        ns;
      logic                        carry;
      logic [3:0]                  fill;
      int unsigned                 i;
      int unsigned                 pass;
      int unsigned                 len;
      if (op == ncda_pkg::OP_SUB) begin
         for (i = 0; i < ncda_pkg::MAX_DIGITS; i++) begin
            b[4*i +: 4] = 4'(ncda_pkg::DEC_NINE - b[4*i +: 4]);
         end
         b_sign = ~b_sign;
      end
      r = digit_row_add(a, a_sign, b, b_sign, rs, carry);
      status = ncda_pkg::STATUS_OK;
      if (a_sign == b_sign) begin
         if (a_sign && !rs) begin
            status = ncda_pkg::STATUS_NEG_OVF;
         end else if (!a_sign && rs) begin
            status = ncda_pkg::STATUS_POS_OVF;
         end
      end
      // End-around carry; a second one can only come from non-decimal digits.
      for (pass = 0; pass < 2 && carry; pass++) begin
         nr = digit_row_add(r, rs, ncda_pkg::DATA_W'(1), 1'b0, ns, carry);
         if (status == ncda_pkg::STATUS_OK && !rs && ns) begin
            status = ncda_pkg::STATUS_POS_OVF;
         end
         r  = nr;
         rs = ns;
      end
      fill = rs ? 4'(ncda_pkg::DEC_NINE) : 4'd0;
      len = 1;
      for (i = 0; i < ncda_pkg::MAX_DIGITS; i++) begin
         if (r[4*i +: 4] != fill) begin
            len = i + 1;
         end
      end
      res.sum_digits = r;
      res.sum_sign   = rs;
      res.sig_length = ncda_pkg::LEN_W'(len);
      res.status     = status;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_sums.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = ncda_pkg::ncda_result_type'(rsp_tdata);
            if (expected_sums.size() == 0) begin
               $error("response transaction with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_sums.pop_front();
               if (got.sum_digits !== want.sum_digits) begin
                  $error("sum_digits: expected %h, actual %h", want.sum_digits, got.sum_digits);
                  errors++;
               end
               if (got.sum_sign !== want.sum_sign) begin
                  $error("sum_sign: expected %b, actual %b", want.sum_sign, got.sum_sign);
                  errors++;
               end
               if (got.sig_length !== want.sig_length) begin
                  $error("sig_length: expected %0d, actual %0d", want.sig_length,
                         got.sig_length);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_sums.push_back(decimal_sum(
               ncda_pkg::ncda_op_type'(req_tuser),
               req_tdata[ncda_pkg::REQ_A_LSB +: ncda_pkg::DATA_W],
               req_tdata[ncda_pkg::REQ_A_SIGN],
               req_tdata[ncda_pkg::REQ_B_LSB +: ncda_pkg::DATA_W],
               req_tdata[ncda_pkg::REQ_B_SIGN]));
         end
      end
      waiting = expected_sums.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the nines' complement decimal adder testbench: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on ncda_pkg, nines_complement_decimal_adder_core and ncda_checker.
module testbench;

   localparam int unsigned ITEM_COUNT   = 1700;
   localparam int unsigned QUIET_TAIL   = 200;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 2 * ncda_pkg::MAX_DIGITS + 20;
   localparam int unsigned DATA_W       = ncda_pkg::DATA_W;
   localparam int unsigned NINE         = ncda_pkg::DEC_NINE;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ncda_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ncda_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             gaps_on = 1'b1;
   int unsigned                      stall_left = 0;
   int unsigned                      quiet_cycles = 0;
   int unsigned                      error_count;
   int unsigned                      pending;

   always #5 clock = ~clock;

   nines_complement_decimal_adder_core #(
      .DIGITS(ncda_pkg::MAX_DIGITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ncda_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending)
   );

   // Receiver back-pressure in randomly started bursts of random length.
   always @(negedge clock) begin
      if (!gaps_on) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_operands(
      input ncda_pkg::ncda_op_type op,
      input logic [DATA_W-1:0]     a,
      input logic                  a_sign,
      input logic [DATA_W-1:0]     b,
      input logic                  b_sign
   );
      logic [ncda_pkg::REQ_TDATA_W-1:0] word;
      int unsigned                      gap;
      word = '0;
      word[ncda_pkg::REQ_A_LSB +: DATA_W] = a;
      word[ncda_pkg::REQ_A_SIGN]          = a_sign;
      word[ncda_pkg::REQ_B_LSB +: DATA_W] = b;
      word[ncda_pkg::REQ_B_SIGN]          = b_sign;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly well-formed operands of random length, with some full-scale
   // values, some raw bit patterns and some with one non-decimal digit.
   task automatic random_operand(output logic [DATA_W-1:0] digits, output logic sign);
      int unsigned kind;
      int unsigned len;
      int unsigned spot;
      int unsigned i;
      logic [3:0]  fill;
      kind = $urandom_range(0, 19);
      sign = 1'($urandom_range(0, 1));
      fill = sign ? 4'(NINE) : 4'd0;
      if (kind < 3) begin
         digits = {$urandom, $urandom};
      end else if (kind < 5) begin
         digits = sign ? '0 : {ncda_pkg::MAX_DIGITS{4'(NINE)}};
      end else begin
         len = $urandom_range(1, ncda_pkg::MAX_DIGITS);
         for (i = 0; i < ncda_pkg::MAX_DIGITS; i++) begin
            digits[4*i +: 4] = (i < len) ? 4'($urandom_range(0, NINE)) : fill;
         end
         if (kind == 5) begin
            spot = $urandom_range(0, ncda_pkg::MAX_DIGITS - 1);
            digits[4*spot +: 4] = 4'($urandom_range(ncda_pkg::DEC_BASE, 15));
         end
      end
   endtask

   initial begin
      logic [DATA_W-1:0]     a;
      logic [DATA_W-1:0]     b;
      logic                  a_sign;
      logic                  b_sign;
      ncda_pkg::ncda_op_type op;
      int unsigned           n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zeros, both forms of zero, overflow in each direction, end-around
      // carry, non-decimal digits and an end-around carry that turns a plus
      // sum minus and then carries a second time.
      send_operands(ncda_pkg::OP_ADD, 64'h0, 1'b0, 64'h0, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h0, 1'b0, 64'h0, 1'b0);
      send_operands(ncda_pkg::OP_ADD, 64'h0, 1'b0, 64'h9999_9999_9999_9999, 1'b1);
      send_operands(ncda_pkg::OP_ADD, 64'h9999_9999_9999_9999, 1'b1,
                    64'h9999_9999_9999_9999, 1'b1);
      send_operands(ncda_pkg::OP_ADD, 64'h9999_9999_9999_9999, 1'b0, 64'h1, 1'b0);
      send_operands(ncda_pkg::OP_ADD, 64'h0, 1'b1, 64'h9999_9999_9999_9998, 1'b1);
      send_operands(ncda_pkg::OP_ADD, 64'h5, 1'b0, 64'h9999_9999_9999_9996, 1'b1);
      send_operands(ncda_pkg::OP_SUB, 64'h3, 1'b0, 64'h5, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h5, 1'b0, 64'h3, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h0, 1'b1, 64'h9999_9999_9999_9999, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h9999_9999_9999_9999, 1'b0, 64'h0, 1'b1);
      send_operands(ncda_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                    64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                    64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_operands(ncda_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                    64'h5555_5555_5555_5555, 1'b0);
      send_operands(ncda_pkg::OP_ADD, 64'h9999_9999_9999_999F, 1'b1,
                    64'h9999_9999_9999_999E, 1'b0);
      send_operands(ncda_pkg::OP_ADD, 64'h1234_5678_9, 1'b0, 64'h9876_5432_1, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h1, 1'b0, 64'h1, 1'b0);
      send_operands(ncda_pkg::OP_SUB, 64'h9999_9999_9999_9998, 1'b1,
                    64'h9999_9999_9999_9998, 1'b1);

      for (n = 0; n < ITEM_COUNT; n++) begin
         // Idle-free stretches every fourth block and throughout the tail.
         gaps_on <= ((n / 150) % 4 != 3) && (n < ITEM_COUNT - QUIET_TAIL);
         op = ncda_pkg::ncda_op_type'($urandom_range(0, 1));
         random_operand(a, a_sign);
         random_operand(b, b_sign);
         send_operands(op, a, a_sign, b, b_sign);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
